[design/mcpid_pkg.sv]
`timescale 1ns / 1ps
// mcpid_pkg: widths, register indexes, reset values and shared structs
// for the multi-channel pid motor drive; no dependencies
package mcpid_pkg;

    localparam int MOTOR_COUNT   = 4;
    localparam int MOTOR_W       = 2;
    localparam int HISTORY_DEPTH = 3;
    localparam int SLOT_W        = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

    localparam int ERR_W      = 16;
    localparam int GAIN_W     = 16;
    localparam int OFS_W      = 12;
    localparam int LIM_W      = 15;
    localparam int INT_W      = 32;
    localparam int DRV_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CORR_SHIFT = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_LIMIT = 3'd4;

    localparam logic signed [GAIN_W-1:0] RST_GAIN_P      = 16'sd200;
    localparam logic signed [GAIN_W-1:0] RST_GAIN_I      = 16'sd10;
    localparam logic signed [GAIN_W-1:0] RST_GAIN_D      = 16'sd200;
    localparam logic        [OFS_W-1:0]  RST_DEADBAND    = 12'd100;
    localparam logic        [LIM_W-1:0]  RST_DRIVE_LIMIT = 15'd3000;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic        [OFS_W-1:0]  deadband_offset;
        logic        [LIM_W-1:0]  drive_limit;
    } cfg_t;

    typedef struct packed {
        logic signed [INT_W-1:0] integral;
        logic signed [ERR_W-1:0] past_err;
        logic        [SLOT_W-1:0] slot;
        logic                    clamp;
    } chan_state_t;

    typedef struct packed {
        logic                    we;
        logic        [MOTOR_W-1:0] motor;
        logic signed [INT_W-1:0] integral;
        logic        [SLOT_W-1:0] slot;
        logic        [SLOT_W-1:0] next_slot;
        logic signed [ERR_W-1:0] err;
        logic                    clamp;
    } chan_update_t;

endpackage

[design/multi_channel_pid_motor_drive.sv]
`timescale 1ns / 1ps
// multi_channel_pid_motor_drive: four-motor pid controller with anti-windup
// depends on mcpid_pkg, mcpid_state, mcpid_calc
// result path: input register, then result register, loaded when the output side can advance
// throughput: 1 item per cycle unless m_ready stalls the result; per-motor state updates as the result registers
// reset: synchronous active-low aresetn clears state and valid flags, loads default gains, dead band and limit
module multi_channel_pid_motor_drive (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [mcpid_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mcpid_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [mcpid_pkg::MOTOR_W-1:0]          s_motor_index,
    input  logic signed [mcpid_pkg::ERR_W-1:0]     s_position_error,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [mcpid_pkg::DRV_W-1:0]     m_drive_value,
    output logic                                   m_saturated
);

    mcpid_pkg::cfg_t cfg_reg;

    logic                                in_vld_reg, in_vld_next;
    logic [mcpid_pkg::MOTOR_W-1:0]       in_motor_reg;
    logic signed [mcpid_pkg::ERR_W-1:0]  in_err_reg;
    logic                                out_vld_reg, out_vld_next;
    logic signed [mcpid_pkg::DRV_W-1:0]  out_drive_reg, out_drive_next;
    logic                                out_sat_reg, out_sat_next;

    logic                    advance;
    logic                    fire;
    mcpid_pkg::chan_state_t  st;
    mcpid_pkg::chan_update_t upd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_p          <= mcpid_pkg::RST_GAIN_P;
            cfg_reg.gain_i          <= mcpid_pkg::RST_GAIN_I;
            cfg_reg.gain_d          <= mcpid_pkg::RST_GAIN_D;
            cfg_reg.deadband_offset <= mcpid_pkg::RST_DEADBAND;
            cfg_reg.drive_limit     <= mcpid_pkg::RST_DRIVE_LIMIT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                mcpid_pkg::CFG_GAIN_P: begin
                    cfg_reg.gain_p <= cfg_wdata;
                end
                mcpid_pkg::CFG_GAIN_I: begin
                    cfg_reg.gain_i <= cfg_wdata;
                end
                mcpid_pkg::CFG_GAIN_D: begin
                    cfg_reg.gain_d <= cfg_wdata;
                end
                mcpid_pkg::CFG_DEADBAND: begin
                    cfg_reg.deadband_offset <= cfg_wdata[mcpid_pkg::OFS_W-1:0];
                end
                mcpid_pkg::CFG_DRIVE_LIMIT: begin
                    cfg_reg.drive_limit <= cfg_wdata[mcpid_pkg::LIM_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign advance = !out_vld_reg || m_ready;
    assign fire    = in_vld_reg && advance;
    assign s_ready = !in_vld_reg || advance;

    mcpid_state u_state (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_motor (in_motor_reg),
        .rd_state (st),
        .upd      (upd)
    );

    mcpid_calc u_calc (
        .fire        (fire),
        .motor       (in_motor_reg),
        .err         (in_err_reg),
        .st          (st),
        .cfg         (cfg_reg),
        .drive_value (out_drive_next),
        .saturated   (out_sat_next),
        .upd         (upd)
    );

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_valid && s_ready) begin
            in_vld_next = 1'b1;
        end else if (fire) begin
            in_vld_next = 1'b0;
        end
        out_vld_next = out_vld_reg;
        if (fire) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_motor_reg <= s_motor_index;
            in_err_reg   <= s_position_error;
        end
        if (fire) begin
            out_drive_reg <= out_drive_next;
            out_sat_reg   <= out_sat_next;
        end
    end

    assign m_valid       = out_vld_reg;
    assign m_drive_value = out_drive_reg;
    assign m_saturated   = out_sat_reg;

endmodule

[design/mcpid_state.sv]
`timescale 1ns / 1ps
// mcpid_state: per-motor integral, error ring, ring slot and clamp flag
// depends on mcpid_pkg
module mcpid_state (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [mcpid_pkg::MOTOR_W-1:0]  rd_motor,
    output mcpid_pkg::chan_state_t         rd_state,
    input  mcpid_pkg::chan_update_t        upd
);

    logic signed [mcpid_pkg::INT_W-1:0] integral_reg [mcpid_pkg::MOTOR_COUNT];
    logic signed [mcpid_pkg::ERR_W-1:0]
        hist_reg [mcpid_pkg::MOTOR_COUNT][mcpid_pkg::HISTORY_DEPTH];
    logic [mcpid_pkg::SLOT_W-1:0] slot_reg  [mcpid_pkg::MOTOR_COUNT];
    logic                         clamp_reg [mcpid_pkg::MOTOR_COUNT];

    logic [mcpid_pkg::SLOT_W-1:0] rd_slot;

    always_comb begin
        rd_slot = slot_reg[rd_motor];
        if ({1'b0, rd_slot} >= (mcpid_pkg::SLOT_W + 1)'(mcpid_pkg::HISTORY_DEPTH)) begin
            rd_slot = '0;
        end
        rd_state.integral = integral_reg[rd_motor];
        rd_state.past_err = hist_reg[rd_motor][rd_slot];
        rd_state.slot     = rd_slot;
        rd_state.clamp    = clamp_reg[rd_motor];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int m = 0; m < mcpid_pkg::MOTOR_COUNT; m++) begin
                integral_reg[m] <= '0;
                slot_reg[m]     <= '0;
                clamp_reg[m]    <= 1'b0;
                for (int h = 0; h < mcpid_pkg::HISTORY_DEPTH; h++) begin
                    hist_reg[m][h] <= '0;
                end
            end
        end else if (upd.we) begin
            integral_reg[upd.motor]         <= upd.integral;
            hist_reg[upd.motor][upd.slot]   <= upd.err;
            slot_reg[upd.motor]             <= upd.next_slot;
            clamp_reg[upd.motor]            <= upd.clamp;
        end
    end

endmodule

[design/mcpid_calc.sv]
`timescale 1ns / 1ps
// mcpid_calc: pid terms, anti-windup integral, scaling, dead band and clamp
// depends on mcpid_pkg
module mcpid_calc (
    input  logic                                 fire,
    input  logic [mcpid_pkg::MOTOR_W-1:0]        motor,
    input  logic signed [mcpid_pkg::ERR_W-1:0]   err,
    input  mcpid_pkg::chan_state_t               st,
    input  mcpid_pkg::cfg_t                      cfg,
    output logic signed [mcpid_pkg::DRV_W-1:0]   drive_value,
    output logic                                 saturated,
    output mcpid_pkg::chan_update_t              upd
);

    localparam int SUM_W = 50;
    localparam int NEG_W = SUM_W + 1;
    localparam int Q_W   = NEG_W - mcpid_pkg::CORR_SHIFT;

    logic                                motor_ok;
    logic signed [mcpid_pkg::INT_W:0]    acc_wide;
    logic signed [mcpid_pkg::INT_W-1:0]  acc_sat;
    logic signed [mcpid_pkg::INT_W-1:0]  sum_used;
    logic signed [31:0]                  p_term;
    logic signed [47:0]                  i_term;
    logic signed [16:0]                  d_diff;
    logic signed [32:0]                  d_term;
    logic signed [SUM_W-1:0]             total;
    logic signed [NEG_W-1:0]             neg;
    logic signed [NEG_W-1:0]             neg_adj;
    logic signed [Q_W-1:0]               quo;
    logic signed [17:0]                  corr;
    logic signed [17:0]                  drv;
    logic signed [17:0]                  lim;
    logic signed [17:0]                  drv_c;
    logic                                sat_c;

    assign motor_ok = ({1'b0, motor} < (mcpid_pkg::MOTOR_W + 1)'(mcpid_pkg::MOTOR_COUNT));

    // saturating integral update, frozen while the last output was clamped
    always_comb begin
        acc_wide = (mcpid_pkg::INT_W + 1)'(st.integral) + (mcpid_pkg::INT_W + 1)'(err);
        if (acc_wide[mcpid_pkg::INT_W] != acc_wide[mcpid_pkg::INT_W-1]) begin
            acc_sat = acc_wide[mcpid_pkg::INT_W] ? {1'b1, {(mcpid_pkg::INT_W-1){1'b0}}}
                                                 : {1'b0, {(mcpid_pkg::INT_W-1){1'b1}}};
        end else begin
            acc_sat = acc_wide[mcpid_pkg::INT_W-1:0];
        end
        sum_used = st.clamp ? st.integral : acc_sat;
    end

    assign p_term = err * cfg.gain_p;
    assign i_term = sum_used * cfg.gain_i;
    assign d_diff = 17'(err) - 17'(st.past_err);
    assign d_term = d_diff * cfg.gain_d;

    // negate, divide by 256 toward zero and saturate to the signed 16-bit range
    always_comb begin
        total   = SUM_W'(i_term) + SUM_W'(p_term) + SUM_W'(d_term);
        neg     = -NEG_W'(total);
        neg_adj = neg + (neg[NEG_W-1] ? NEG_W'(255) : NEG_W'(0));
        quo     = neg_adj[NEG_W-1:mcpid_pkg::CORR_SHIFT];
        if (quo > Q_W'(32767)) begin
            corr = 18'sd32767;
        end else if (quo < -Q_W'(32768)) begin
            corr = -18'sd32768;
        end else begin
            corr = 18'(quo);
        end
    end

    // dead band away from zero, then limit clamp
    always_comb begin
        if (corr < 0) begin
            drv = corr - 18'($unsigned(cfg.deadband_offset));
        end else begin
            drv = corr + 18'($unsigned(cfg.deadband_offset));
        end
        lim = 18'($unsigned(cfg.drive_limit));
        if (drv > lim) begin
            drv_c = lim;
            sat_c = 1'b1;
        end else if (drv < -lim) begin
            drv_c = -lim;
            sat_c = 1'b1;
        end else begin
            drv_c = drv;
            sat_c = 1'b0;
        end
    end

    always_comb begin
        if (motor_ok) begin
            drive_value = drv_c[mcpid_pkg::DRV_W-1:0];
            saturated   = sat_c;
        end else begin
            drive_value = '0;
            saturated   = 1'b0;
        end
        upd.we        = fire && motor_ok;
        upd.motor     = motor;
        upd.integral  = sum_used;
        upd.slot      = st.slot;
        upd.next_slot = ({1'b0, st.slot} >= (mcpid_pkg::SLOT_W + 1)'(mcpid_pkg::HISTORY_DEPTH - 1))
                        ? '0 : st.slot + 1'b1;
        upd.err       = err;
        upd.clamp     = sat_c;
    end

endmodule

[design/mcpid_checker.sv]
`timescale 1ns / 1ps
// mcpid_checker: port-level checks on the pid motor drive, bound to the top
// depends on mcpid_pkg and multi_channel_pid_motor_drive
module mcpid_checker (
    input logic                                   aclk,
    input logic                                   aresetn,
    input logic                                   s_valid,
    input logic                                   s_ready,
    input logic                                   m_valid,
    input logic                                   m_ready,
    input logic signed [mcpid_pkg::DRV_W-1:0]     m_drive_value,
    input logic                                   m_saturated
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_drive_value) && $stable(m_saturated))
        else $error("result changed while stalled");

    // input only back-pressured when the result side is full and stalled
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output back-pressure");

    // a fresh result follows an accepted item through the input and result registers
    a_rose: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result without a matching item");

    // drive magnitude never exceeds the 15-bit limit range
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_drive_value != 16'sh8000)
        else $error("drive value out of range");

endmodule

bind multi_channel_pid_motor_drive mcpid_checker u_mcpid_checker (.*);
